// File: rtl/core/plint_pkg.sv
// shared types, codes and sizes of the piecewise linear interpolator
// no dependencies; every other file of the block uses this package

package plint_pkg;

	// default table depth
	localparam int MAX_POINTS_DEF = 64;

	// field widths
	localparam int CMD_W  = 2;
	localparam int WL_W   = 16;
	localparam int VAL_W  = 32;
	localparam int FRAC_W = 16;

	// command codes; any code with the high bit set is a query
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam int               CMD_QUERY_BIT = 1;

	typedef enum logic [1:0] {
		STAT_EVAL     = 2'd0,
		STAT_STORED   = 2'd1,
		STAT_CLEARED  = 2'd2,
		STAT_REJECTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SEG_HI,
		S_SEG_EVAL,
		S_DIV,
		S_ADD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] interpolated;
		logic                    in_range;
		status_t                 status;
	} result_t;

	// fraction divider request and response
	typedef struct packed {
		logic            start;
		logic [WL_W-1:0] num;
		logic [WL_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [FRAC_W:0] quot;
	} div_rsp_t;

endpackage

// File: rtl/core/plint_req_if.sv
// input channel of the interpolator: valid/ready plus the command word
// depends on plint_pkg

interface plint_req_if;
	logic                              valid;
	logic                              ready;
	logic [plint_pkg::CMD_W-1:0]       cmd;
	logic [plint_pkg::WL_W-1:0]        wavelength;
	logic signed [plint_pkg::VAL_W-1:0] sample_value;

	modport source (output valid, cmd, wavelength, sample_value, input ready);
	modport sink (input valid, cmd, wavelength, sample_value, output ready);
endinterface

// File: rtl/core/plint_rsp_if.sv
// output channel of the interpolator: valid/ready plus the result word
// depends on plint_pkg

interface plint_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [plint_pkg::VAL_W-1:0] interpolated;
	logic                               in_range;
	logic [1:0]                         status;

	modport source (output valid, interpolated, in_range, status, input ready);
	modport sink (input valid, interpolated, in_range, status, output ready);
endinterface

// File: rtl/core/plint_div.sv
// restoring divider for the segment fraction, one quotient bit per cycle
// depends on plint_pkg; numerator is known not to exceed the denominator

module plint_div (
	input  logic                clk,
	input  logic                arst_n,
	input  plint_pkg::div_req_t req,
	output plint_pkg::div_rsp_t rsp
);

	localparam int QW    = plint_pkg::FRAC_W + 1;
	localparam int RW    = plint_pkg::WL_W + 1;
	localparam int CNT_W = $clog2(QW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RW-1:0]    rem_q;
	logic [RW-2:0]    den_q;
	logic [QW-1:0]    quo_q;
	logic             ge;
	logic [RW-1:0]    diff;

	// trial subtraction
	assign ge   = rem_q >= {1'b0, den_q};
	assign diff = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= {diff[RW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// File: rtl/core/plint_ctrl.sv
// breakpoint memory, binary search sequencer and interpolation datapath
// depends on plint_pkg, plint_req_if and the fraction divider response

module plint_ctrl #(
	parameter int MAX_POINTS = plint_pkg::MAX_POINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	plint_req_if.sink           req,
	output logic                res_valid,
	input  logic                res_ready,
	output plint_pkg::result_t  res,
	output plint_pkg::div_req_t div_req,
	input  plint_pkg::div_rsp_t div_rsp
);

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int WL_W  = plint_pkg::WL_W;
	localparam int VAL_W = plint_pkg::VAL_W;
	localparam int FW    = plint_pkg::FRAC_W;
	localparam int MEM_W = WL_W + VAL_W;
	localparam int PW    = VAL_W + FW + 3;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

	plint_pkg::state_t state_q, state_d;

	logic [CW-1:0]           count_q;
	logic [WL_W-1:0]         first_q, last_q, q_q, lo_wl_q;
	logic [AW-1:0]           lo_q, hi_q, mid_q, mem_ra;
	logic [AW:0]             mid_sum;
	logic [AW-1:0]           mid_c;
	logic [MEM_W-1:0]        mem [MAX_POINTS];
	logic [MEM_W-1:0]        rd_q;
	logic [WL_W-1:0]         rd_wl;
	logic signed [VAL_W-1:0] rd_val;
	logic signed [VAL_W-1:0] v0_q;
	logic signed [VAL_W:0]   dv_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [PW-1:0]    rnd;
	logic                    single_q;
	plint_pkg::result_t      res_q;
	logic                    fire, is_query, is_append, app_ok, miss, mem_we;

	// input decode
	assign fire      = req.valid && req.ready;
	assign is_query  = req.cmd[plint_pkg::CMD_QUERY_BIT];
	assign is_append = req.cmd == plint_pkg::CMD_APPEND;
	assign app_ok    = (count_q != MAX_CNT) &&
		((count_q == '0) || (req.wavelength >= last_q));
	assign miss      = (count_q == '0) || (req.wavelength < first_q) ||
		(req.wavelength > last_q);
	assign mem_we    = fire && !is_query && is_append && app_ok;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (AW + 1)'(1);
	assign mid_c   = mid_sum[AW:1];
	assign rd_wl   = rd_q[MEM_W-1:VAL_W];
	assign rd_val  = signed'(rd_q[VAL_W-1:0]);
	assign rnd     = prod_q + PW'(1 << (FW - 1));

	// breakpoint memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[AW-1:0]] <= {req.wavelength, req.sample_value};
		end
		rd_q <= mem[mem_ra];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plint_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory address and handshakes
	always_comb begin
		state_d     = state_q;
		req.ready   = 1'b0;
		mem_ra      = lo_q;
		div_req     = '0;
		res_valid   = 1'b0;
		case (state_q)
			plint_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (fire) begin
					if (is_query && !miss) begin
						state_d = plint_pkg::S_SRCH_RD;
					end else begin
						state_d = plint_pkg::S_DONE;
					end
				end
			end
			plint_pkg::S_SRCH_RD: begin
				if (lo_q < hi_q) begin
					mem_ra  = mid_c;
					state_d = plint_pkg::S_SRCH_CMP;
				end else begin
					mem_ra  = lo_q;
					state_d = plint_pkg::S_SEG_HI;
				end
			end
			plint_pkg::S_SRCH_CMP: begin
				state_d = plint_pkg::S_SRCH_RD;
			end
			plint_pkg::S_SEG_HI: begin
				mem_ra  = lo_q + AW'(1);
				state_d = plint_pkg::S_SEG_EVAL;
			end
			plint_pkg::S_SEG_EVAL: begin
				if (single_q || (rd_wl <= lo_wl_q)) begin
					state_d = plint_pkg::S_DONE;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = q_q - lo_wl_q;
					div_req.den   = rd_wl - lo_wl_q;
					state_d       = plint_pkg::S_DIV;
				end
			end
			plint_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_d = plint_pkg::S_ADD;
				end
			end
			plint_pkg::S_ADD: begin
				state_d = plint_pkg::S_DONE;
			end
			plint_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = plint_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = plint_pkg::S_IDLE;
			end
		endcase
	end

	// point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire && !is_query) begin
			if (req.cmd == plint_pkg::CMD_CLEAR) begin
				count_q <= '0;
			end else if (app_ok) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// search window, segment operands and result
	always_ff @(posedge clk) begin
		case (state_q)
			plint_pkg::S_IDLE: begin
				if (fire) begin
					q_q      <= req.wavelength;
					lo_q     <= '0;
					hi_q     <= (count_q >= CW'(2)) ? AW'(count_q - CW'(2)) : '0;
					single_q <= count_q == CW'(1);
					res_q.interpolated <= '0;
					res_q.in_range     <= 1'b0;
					if (is_query) begin
						res_q.status <= plint_pkg::STAT_EVAL;
					end else if (!is_append) begin
						res_q.status <= plint_pkg::STAT_CLEARED;
					end else if (app_ok) begin
						res_q.status <= plint_pkg::STAT_STORED;
					end else begin
						res_q.status <= plint_pkg::STAT_REJECTED;
					end
					if (mem_we) begin
						last_q <= req.wavelength;
						if (count_q == '0) begin
							first_q <= req.wavelength;
						end
					end
				end
			end
			plint_pkg::S_SRCH_RD: begin
				mid_q <= mid_c;
			end
			plint_pkg::S_SRCH_CMP: begin
				if (rd_wl <= q_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q - AW'(1);
				end
			end
			plint_pkg::S_SEG_HI: begin
				lo_wl_q <= rd_wl;
				v0_q    <= rd_val;
			end
			plint_pkg::S_SEG_EVAL: begin
				dv_q <= {rd_val[VAL_W-1], rd_val} - {v0_q[VAL_W-1], v0_q};
				res_q.interpolated <= v0_q;
				res_q.in_range     <= 1'b1;
				res_q.status       <= plint_pkg::STAT_EVAL;
			end
			plint_pkg::S_DIV: begin
				if (div_rsp.done) begin
					prod_q <= PW'(dv_q) * PW'(signed'({1'b0, div_rsp.quot}));
				end
			end
			plint_pkg::S_ADD: begin
				res_q.interpolated <= v0_q + signed'(rnd[VAL_W+FW-1:FW]);
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	// table never grows past its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("point count beyond table depth");

	// probe index lies inside the live search window
	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plint_pkg::S_SRCH_CMP) |-> ((mid_q > lo_q) && (mid_q <= hi_q)))
		else $error("search probe outside window");

	// chosen segment brackets the query point
	a_seg_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == plint_pkg::S_SEG_EVAL) && !single_q) |->
		((lo_wl_q <= q_q) && (rd_wl >= q_q)))
		else $error("segment does not bracket query");

	// divider finishes only while the sequencer waits for it
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == plint_pkg::S_DIV))
		else $error("divider result outside divide state");

	// a hit is only ever reported for a query
	a_hit_is_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_q.in_range) |-> (res_q.status == plint_pkg::STAT_EVAL))
		else $error("in-range flag on a non-query word");

endmodule

// File: rtl/core/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a table of up to MAX_POINTS ascending breakpoints
// (wavelength unsigned Q10.6, value signed Q16.16). Each input word clears the table,
// appends a breakpoint, or queries a wavelength, and gives exactly one result word.
// One word is in work at a time; a finished result waits in the output register while
// the next input word is taken. Clear, append and out-of-range queries go from idle
// straight to the result state. An in-range query makes k binary-search probes, where
// k <= ceil(log2(points - 1)): each probe takes a read state and a compare state on
// the single read port of the breakpoint memory, and the fraction divider retires
// one quotient bit per cycle for 17 bits. A query on a single breakpoint or on a
// zero-width segment skips the divider.
// No clearing pass is needed after reset.
// Depends on plint_pkg, plint_req_if, plint_rsp_if, plint_div and plint_ctrl.

module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = plint_pkg::MAX_POINTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	plint_req_if.sink    req,
	plint_rsp_if.source  rsp
);

	plint_pkg::result_t  res, out_q;
	plint_pkg::div_req_t div_req;
	plint_pkg::div_rsp_t div_rsp;
	logic                res_valid, res_ready, out_valid_q;

	plint_ctrl #(
		.MAX_POINTS (MAX_POINTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	plint_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// output register, free when empty or being drained
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.interpolated = out_q.interpolated;
	assign rsp.in_range     = out_q.in_range;
	assign rsp.status       = out_q.status;

endmodule
